FILE: design/running_mean_stddev_mad_unit_macros.svh
// Assertion macros for the running mean / deviation unit.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef RUNNING_MEAN_STDDEV_MAD_UNIT_MACROS_SVH
`define RUNNING_MEAN_STDDEV_MAD_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RMSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmsm check failed");
// next-cycle implication
`define RMSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmsm check failed");
`else
`define RMSM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RMSM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/rmsm_pkg.sv
// Shared widths, sizes and the job record for the running statistics unit.
// No dependencies.
`timescale 1ns / 1ps
package rmsm_pkg;
   localparam int MAX_SAMPLES = 64;
   localparam int SAMPLE_W    = 16;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int SUM_W       = SAMPLE_W + CNT_W;
   localparam int SQ_W        = 2 * SAMPLE_W - 1 + CNT_W;
   localparam int PA_W        = CNT_W + SQ_W;
   localparam int D_W         = 2 * SUM_W;
   localparam int FRAC_W      = 8;
   localparam int VAR_SHIFT   = 2 * FRAC_W;
   localparam int DIV_W       = D_W + VAR_SHIFT;
   localparam int DIVC_W      = $clog2(DIV_W + 1);
   localparam int DEN_W       = 2 * CNT_W;
   localparam int P_W         = CNT_W + 1 + SAMPLE_W;
   localparam int DEV_W       = P_W + 1;
   localparam int AB_W        = DEV_W + CNT_W;
   localparam int MEAN_NB     = SUM_W + FRAC_W;
   localparam int MAD_NB      = AB_W + FRAC_W;
   localparam int SQ_STEPS    = (DIV_W + 1) / 2;
   localparam int SQRT_W      = 2 * SQ_STEPS;
   localparam int OUT_W       = 24;
   localparam int COUNT_OUT_W = 7;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sumsq;
      logic                    ovf;
   } job_type;

   typedef struct packed {
      logic busy;
      logic q_empty;
   } back_status_type;
endpackage

FILE: design/running_mean_stddev_mad_unit.sv
// Top level of the running mean / standard deviation / mean absolute deviation unit.
// Depends on rmsm_pkg, rmsm_front, rmsm_queue, rmsm_back, rmsm_ram.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | req_sample, req_start_req
//   rsp_    | out       | rsp_valid/rsp_ready  | rsp_count, rsp_mean, rsp_std_dev,
//           |           |                      | rsp_mean_abs_dev, rsp_overflow
//
// Each transaction passes through the back part in order: a mean divide (overlapped
// with the store walk), a variance divide, an integer root and a deviation divide;
// with fewer than two samples the variance and root are skipped.
// The shared divider works at one bit per cycle.
// Reset is synchronous and active high; the store is not cleared.
// A two-entry job queue lets the front take transactions while the back works; a
// restart transaction waits until the back has drained, since it rewrites the store.
`timescale 1ns / 1ps
module running_mean_stddev_mad_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rmsm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_start_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rmsm_pkg::COUNT_OUT_W-1:0]      rsp_count,
   output logic signed [rmsm_pkg::OUT_W-1:0]     rsp_mean,
   output logic [rmsm_pkg::OUT_W-1:0]            rsp_std_dev,
   output logic [rmsm_pkg::OUT_W-1:0]            rsp_mean_abs_dev,
   output logic                                  rsp_overflow
);
   rmsm_pkg::job_type           push_job, head_job;
   rmsm_pkg::back_status_type   status;
   logic                        q_push, q_pop, q_full, q_empty, back_busy;
   logic                        ram_we, ram_re;
   logic [rmsm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [rmsm_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;

   assign status.busy    = back_busy;
   assign status.q_empty = q_empty;

   // front: bookkeeping and sample store writes
   rmsm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_start_req (req_start_req),
      .status        (status),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata)
   );

   rmsm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // sample store: written by the front, walked by the back
   rmsm_ram #(
      .WIDTH (rmsm_pkg::SAMPLE_W),
      .DEPTH (rmsm_pkg::MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // back: statistics and the result register
   rmsm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (!q_empty),
      .q_job            (head_job),
      .q_pop            (q_pop),
      .ram_re           (ram_re),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .busy             (back_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_count        (rsp_count),
      .rsp_mean         (rsp_mean),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_mean_abs_dev (rsp_mean_abs_dev),
      .rsp_overflow     (rsp_overflow)
   );
endmodule

FILE: design/rmsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rmsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/rmsm_queue.sv
// Short job queue between the front and back parts.
// Depends on rmsm_pkg.
`timescale 1ns / 1ps
module rmsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rmsm_pkg::job_type push_job,
   input  logic              pop,
   output rmsm_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);
   rmsm_pkg::job_type mem_ff [rmsm_pkg::QDEPTH];
   logic [rmsm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rmsm_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rmsm_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rmsm_pkg::QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + rmsm_pkg::QCNT_W'(push) - rmsm_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = mem_ff[rd_ptr_ff];
   assign full     = (cnt_ff == rmsm_pkg::QCNT_W'(rmsm_pkg::QDEPTH));
   assign empty    = (cnt_ff == '0);
endmodule

FILE: design/rmsm_front.sv
// Front part: accepts samples, keeps count/sum/sum of squares, stores samples.
// Depends on rmsm_pkg.
`timescale 1ns / 1ps
module rmsm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [rmsm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                            req_start_req,
   input  rmsm_pkg::back_status_type       status,
   input  logic                            q_full,
   output logic                            q_push,
   output rmsm_pkg::job_type               q_job,
   output logic                            ram_we,
   output logic [rmsm_pkg::ADDR_W-1:0]     ram_waddr,
   output logic [rmsm_pkg::SAMPLE_W-1:0]   ram_wdata
);
   logic [rmsm_pkg::CNT_W-1:0]        count_ff, count_in, base_cnt;
   logic signed [rmsm_pkg::SUM_W-1:0] sum_ff, sum_in, base_sum;
   logic [rmsm_pkg::SQ_W-1:0]         sumsq_ff, sumsq_in, base_sq;
   logic signed [2*rmsm_pkg::SAMPLE_W-1:0] sq;
   logic full;
   logic accept;

   // a restart rewrites low store entries, so wait until nothing older reads them
   assign req_ready = !q_full && !(req_start_req && (status.busy || !status.q_empty));
   assign accept    = req_valid && req_ready;

   always_comb begin
      base_cnt = req_start_req ? '0 : count_ff;
      base_sum = req_start_req ? '0 : sum_ff;
      base_sq  = req_start_req ? '0 : sumsq_ff;
      full     = (base_cnt >= rmsm_pkg::CNT_W'(rmsm_pkg::MAX_SAMPLES));
      sq       = req_sample * req_sample;
      if (full) begin
         count_in = base_cnt;
         sum_in   = base_sum;
         sumsq_in = base_sq;
      end else begin
         count_in = base_cnt + rmsm_pkg::CNT_W'(1);
         sum_in   = base_sum + rmsm_pkg::SUM_W'(req_sample);
         sumsq_in = base_sq + rmsm_pkg::SQ_W'(unsigned'(sq));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
      end
   end

   assign q_push      = accept;
   assign q_job.count = count_in;
   assign q_job.sum   = sum_in;
   assign q_job.sumsq = sumsq_in;
   assign q_job.ovf   = full;
   assign ram_we      = accept && !full;
   assign ram_waddr   = base_cnt[rmsm_pkg::ADDR_W-1:0];
   assign ram_wdata   = req_sample;
endmodule

FILE: design/rmsm_back.sv
// Back part: mean, variance divide, integer root, deviation walk, result register.
// Depends on rmsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "running_mean_stddev_mad_unit_macros.svh"
module rmsm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  rmsm_pkg::job_type                   q_job,
   output logic                                q_pop,
   output logic                                ram_re,
   output logic [rmsm_pkg::ADDR_W-1:0]         ram_raddr,
   input  logic [rmsm_pkg::SAMPLE_W-1:0]       ram_rdata,
   output logic                                busy,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rmsm_pkg::COUNT_OUT_W-1:0]    rsp_count,
   output logic signed [rmsm_pkg::OUT_W-1:0]   rsp_mean,
   output logic [rmsm_pkg::OUT_W-1:0]          rsp_std_dev,
   output logic [rmsm_pkg::OUT_W-1:0]          rsp_mean_abs_dev,
   output logic                                rsp_overflow
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MEAN = 3'd1;
   localparam logic [2:0] ST_VAR  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_MADW = 3'd4;
   localparam logic [2:0] ST_MAD  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;

   // job
   logic [rmsm_pkg::CNT_W-1:0]        n_ff;
   logic signed [rmsm_pkg::SUM_W-1:0] s_ff;
   logic [rmsm_pkg::SQ_W-1:0]         sq_ff;
   logic                              ovf_ff;

   // variance numerator pipeline
   logic [rmsm_pkg::PA_W-1:0]        pa_ff;
   logic signed [rmsm_pkg::D_W-1:0]  pb_ff;
   logic [rmsm_pkg::D_W-1:0]         d_ff;
   logic signed [rmsm_pkg::D_W:0]    d_diff;

   // shared restoring divider
   logic [rmsm_pkg::DIV_W-1:0]  div_dvd_ff, div_dvd_step, div_load_dvd;
   logic [rmsm_pkg::DEN_W-1:0]  div_rem_ff, div_rem_step, div_dvs_ff, div_load_dvs;
   logic [rmsm_pkg::DIVC_W-1:0] div_cnt_ff, div_load_nb;
   logic [rmsm_pkg::DEN_W:0]    div_rem_sh;
   logic                        div_ge, div_start;

   // integer square root
   logic [rmsm_pkg::SQRT_W-1:0] sq_v_ff, sq_root_ff, sq_bit_ff, sq_trial;
   logic                        sq_load, sq_ge;

   // deviation walk
   logic [rmsm_pkg::CNT_W-1:0]        widx_ff;
   logic                              v1_ff, v2_ff;
   logic signed [rmsm_pkg::P_W-1:0]   prod_ff;
   logic signed [rmsm_pkg::DEV_W-1:0] dev;
   logic [rmsm_pkg::DEV_W-1:0]        adev;
   logic [rmsm_pkg::AB_W-1:0]         absum_ff;
   logic                              walk_done;

   // results
   logic [rmsm_pkg::OUT_W-1:0]        mean_ff, sd_ff, mad_ff;
   logic [rmsm_pkg::MEAN_NB-1:0]      mq, mean_val;
   logic [rmsm_pkg::MAD_NB-1:0]       madq;
   logic [rmsm_pkg::OUT_W-1:0]        sd_sat, mad_sat;
   logic                              out_load;
   logic                              rsp_valid_ff;
   logic [rmsm_pkg::COUNT_OUT_W-1:0]  out_count_ff;
   logic [rmsm_pkg::OUT_W-1:0]        out_mean_ff, out_sd_ff, out_mad_ff;
   logic                              out_ovf_ff;

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign busy  = (state_ff != ST_IDLE);

   // divider step
   always_comb begin
      div_rem_sh   = {div_rem_ff, div_dvd_ff[rmsm_pkg::DIV_W-1]};
      div_ge       = (div_rem_sh >= {1'b0, div_dvs_ff});
      div_rem_step = div_ge ? rmsm_pkg::DEN_W'(div_rem_sh - {1'b0, div_dvs_ff})
                            : div_rem_sh[rmsm_pkg::DEN_W-1:0];
      div_dvd_step = {div_dvd_ff[rmsm_pkg::DIV_W-2:0], div_ge};
   end

   // root step
   always_comb begin
      sq_trial = sq_root_ff + sq_bit_ff;
      sq_ge    = (sq_v_ff >= sq_trial);
   end

   // walk arithmetic
   always_comb begin
      ram_re    = (widx_ff < n_ff);
      ram_raddr = widx_ff[rmsm_pkg::ADDR_W-1:0];
      dev       = {prod_ff[rmsm_pkg::P_W-1], prod_ff}
                  - {{(rmsm_pkg::DEV_W-rmsm_pkg::SUM_W){s_ff[rmsm_pkg::SUM_W-1]}}, s_ff};
      adev      = dev[rmsm_pkg::DEV_W-1] ? rmsm_pkg::DEV_W'(-dev) : rmsm_pkg::DEV_W'(dev);
      walk_done = (widx_ff == n_ff) && !v1_ff && !v2_ff;
   end

   // result shaping
   always_comb begin
      mq       = div_dvd_ff[rmsm_pkg::MEAN_NB-1:0];
      mean_val = s_ff[rmsm_pkg::SUM_W-1] ? -mq : mq;
      madq     = div_dvd_ff[rmsm_pkg::MAD_NB-1:0];
      sd_sat   = (|sq_root_ff[rmsm_pkg::SQRT_W-1:rmsm_pkg::OUT_W]) ? '1
                 : sq_root_ff[rmsm_pkg::OUT_W-1:0];
      mad_sat  = (|madq[rmsm_pkg::MAD_NB-1:rmsm_pkg::OUT_W]) ? '1
                 : madq[rmsm_pkg::OUT_W-1:0];
      d_diff   = $signed({2'b00, pa_ff}) - $signed({1'b0, pb_ff});
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_load_dvd = '0;
      div_load_dvs = '0;
      div_load_nb  = '0;
      sq_load      = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            // mean divide gets started on entry (see registers)
            if (div_cnt_ff == '0) begin
               if (n_ff > rmsm_pkg::CNT_W'(1)) begin
                  div_start    = 1'b1;
                  div_load_dvd = {d_ff, {rmsm_pkg::VAR_SHIFT{1'b0}}};
                  div_load_dvs = rmsm_pkg::DEN_W'(n_ff)
                                 * rmsm_pkg::DEN_W'(n_ff - rmsm_pkg::CNT_W'(1));
                  div_load_nb  = rmsm_pkg::DIVC_W'(rmsm_pkg::DIV_W);
                  state_in     = ST_VAR;
               end else begin
                  state_in = ST_MADW;
               end
            end
         end
         ST_VAR: begin
            if (div_cnt_ff == '0) begin
               sq_load  = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_bit_ff == '0) begin
               state_in = ST_MADW;
            end
         end
         ST_MADW: begin
            if (walk_done) begin
               div_start    = 1'b1;
               div_load_dvd = rmsm_pkg::DIV_W'({absum_ff, {rmsm_pkg::FRAC_W{1'b0}}})
                              << (rmsm_pkg::DIV_W - rmsm_pkg::MAD_NB);
               div_load_dvs = rmsm_pkg::DEN_W'(n_ff) * rmsm_pkg::DEN_W'(n_ff);
               div_load_nb  = rmsm_pkg::DIVC_W'(rmsm_pkg::MAD_NB);
               state_in     = ST_MAD;
            end
         end
         ST_MAD: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         sq_bit_ff    <= '0;
         widx_ff      <= '0;
         n_ff         <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= ram_re;
         v2_ff    <= v1_ff;
         if (q_pop) begin
            n_ff    <= q_job.count;
            widx_ff <= '0;
         end else if (ram_re) begin
            widx_ff <= widx_ff + rmsm_pkg::CNT_W'(1);
         end
         if (q_pop) begin
            div_cnt_ff <= rmsm_pkg::DIVC_W'(rmsm_pkg::MEAN_NB);
         end else if (div_start) begin
            div_cnt_ff <= div_load_nb;
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - rmsm_pkg::DIVC_W'(1);
         end
         if (sq_load) begin
            sq_bit_ff <= rmsm_pkg::SQRT_W'(1) << (rmsm_pkg::SQRT_W - 2);
         end else if (state_ff == ST_SQRT && sq_bit_ff != '0) begin
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pa_ff <= n_ff * sq_ff;
      pb_ff <= s_ff * s_ff;
      d_ff  <= d_diff[rmsm_pkg::D_W] ? '0 : d_diff[rmsm_pkg::D_W-1:0];
      if (q_pop) begin
         s_ff       <= q_job.sum;
         sq_ff      <= q_job.sumsq;
         ovf_ff     <= q_job.ovf;
         absum_ff   <= '0;
         sd_ff      <= '0;
         // the mean divide needs the new sum, so it loads from the queue head
         div_dvd_ff <= rmsm_pkg::DIV_W'({(q_job.sum[rmsm_pkg::SUM_W-1]
                          ? rmsm_pkg::SUM_W'(-q_job.sum) : rmsm_pkg::SUM_W'(q_job.sum)),
                          {rmsm_pkg::FRAC_W{1'b0}}}) << (rmsm_pkg::DIV_W - rmsm_pkg::MEAN_NB);
         div_rem_ff <= '0;
         div_dvs_ff <= rmsm_pkg::DEN_W'(q_job.count);
      end else begin
         if (v2_ff) begin
            absum_ff <= absum_ff + rmsm_pkg::AB_W'(adev);
         end
         if (div_start) begin
            div_dvd_ff <= div_load_dvd;
            div_rem_ff <= '0;
            div_dvs_ff <= div_load_dvs;
         end else if (div_cnt_ff != '0) begin
            div_dvd_ff <= div_dvd_step;
            div_rem_ff <= div_rem_step;
         end
         if (state_ff == ST_SQRT && sq_bit_ff == '0) begin
            sd_ff <= sd_sat;
         end
      end
      if (v1_ff) begin
         prod_ff <= $signed({1'b0, n_ff}) * $signed(ram_rdata);
      end
      if (state_ff == ST_MEAN && div_cnt_ff == '0) begin
         mean_ff <= mean_val[rmsm_pkg::OUT_W-1:0];
      end
      if (state_ff == ST_MAD && div_cnt_ff == '0) begin
         mad_ff <= mad_sat;
      end
      if (sq_load) begin
         sq_v_ff    <= rmsm_pkg::SQRT_W'(div_dvd_ff);
         sq_root_ff <= '0;
      end else if (state_ff == ST_SQRT && sq_bit_ff != '0) begin
         if (sq_ge) begin
            sq_v_ff    <= sq_v_ff - sq_trial;
            sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
         end else begin
            sq_root_ff <= sq_root_ff >> 1;
         end
      end
      if (out_load) begin
         out_count_ff <= rmsm_pkg::COUNT_OUT_W'(n_ff);
         out_mean_ff  <= mean_ff;
         out_sd_ff    <= sd_ff;
         out_mad_ff   <= mad_ff;
         out_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count        = out_count_ff;
   assign rsp_mean         = out_mean_ff;
   assign rsp_std_dev      = out_sd_ff;
   assign rsp_mean_abs_dev = out_mad_ff;
   assign rsp_overflow     = out_ovf_ff;

   `RMSM_ASSERT_IMP(a_pop_only_idle, clock, reset, q_pop, state_ff == ST_IDLE)
   `RMSM_ASSERT_IMP(a_walk_in_set, clock, reset, ram_re, widx_ff < n_ff)
   `RMSM_ASSERT_NXT(a_root_exit, clock, reset, (state_ff == ST_SQRT) && (sq_bit_ff == '0),
                    state_ff == ST_MADW)
   `RMSM_ASSERT_NXT(a_done_loads, clock, reset, out_load, rsp_valid_ff)
endmodule
